// ===== rtl/core/srsa_pkg.sv =====
// shared types and constants of the small-modulus rsa block
package srsa_pkg;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BAD_P = 3'd1;
	localparam logic [2:0] ST_BAD_Q = 3'd2;
	localparam logic [2:0] ST_NO_E  = 3'd3;
	localparam logic [2:0] ST_NO_D  = 3'd4;

	// configuration register indexes
	localparam logic CFG_PRIME_P = 1'b0;
	localparam logic CFG_PRIME_Q = 1'b1;

	// request to the serial multiply-divide unit: q,r = (a*b + c) divmod m
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        c;
		logic [31:0] m;
	} mdu_req_t;

	typedef struct packed {
		logic [63:0] q;
		logic [31:0] r;
	} mdu_rsp_t;

endpackage

// ===== rtl/core/srsa_mdu.sv =====
// bit-serial multiply then restoring divide unit
module srsa_mdu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  srsa_pkg::mdu_req_t req,
	output logic              done,
	output srsa_pkg::mdu_rsp_t rsp
);
	import srsa_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]  ph_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        c_q;
	logic [31:0] m_q;
	logic [63:0] acc_q;
	logic [31:0] rem_q;
	logic        done_q;

	logic [63:0] mul_next;
	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_new;

	// one multiplier bit per cycle, msb first
	assign mul_next = {acc_q[62:0], 1'b0} + (b_q[31] ? {32'd0, a_q} : 64'd0);

	// one quotient bit per cycle
	assign rem_sh  = {rem_q, acc_q[63]};
	assign ge      = rem_sh >= {1'b0, m_q};
	assign rem_new = ge ? (rem_sh - {1'b0, m_q}) : rem_sh;

	// sequencing of the two phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= 1'b0;
			m_q    <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				PH_IDLE: begin
					if (start) begin
						a_q   <= req.a;
						b_q   <= req.b;
						c_q   <= req.c;
						m_q   <= req.m;
						acc_q <= '0;
						cnt_q <= '0;
						ph_q  <= PH_MUL;
					end
				end
				PH_MUL: begin
					acc_q <= mul_next;
					b_q   <= {b_q[30:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						acc_q <= mul_next + {63'd0, c_q};
						cnt_q <= '0;
						rem_q <= '0;
						ph_q  <= PH_DIV;
					end
				end
				PH_DIV: begin
					acc_q <= {acc_q[62:0], ge};
					rem_q <= rem_new[31:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						ph_q   <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign rsp.q = acc_q;
	assign rsp.r = rem_q;

endmodule

// ===== rtl/core/small_rsa_keygen_and_modexp.sv =====
// top level: textbook rsa key setup and round trip over a small modulus
//
// Usage: write prime_p (index 0) and prime_q (index 1) on the cfg channel
// (cfg_ready is always high) while the block is idle. Each beat on the input
// channel carries one plaintext word; the block returns one result beat with
// ciphertext, recovered value, both exponents, modulus and status.
// Input is taken only while the sequencer is idle (in_stall low); the
// finished result sits in an output register, so the next plaintext can be
// taken while the result still waits on out_stall.
// Every arithmetic step runs on one shared bit-serial unit, which first
// multiplies and then divides. An item issues to it, in order and as far
// as it gets, trial divisions of both primes, the modulus and totient
// products, the gcd steps of the exponent search, the message reduction,
// the multiplies and squares of the public-exponent modexp, the inverse
// search tries and the multiplies and squares of the private-exponent modexp.
// One item is worked at a time.
// Reset: primes return to 61 and 53, no result is pending.
// When the receiver stalls, the result holds and the sequencer waits in
// its final state until the output register is free.
module small_rsa_keygen_and_modexp #(
	parameter int PRIME_BITS           = 16,
	parameter int INVERSE_SEARCH_LIMIT = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] plaintext,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] ciphertext,
	output logic [31:0] recovered,
	output logic [31:0] public_exponent,
	output logic [31:0] private_exponent,
	output logic [31:0] modulus,
	output logic [2:0]  status
);
	import srsa_pkg::*;

	localparam logic [15:0] PMASK = (PRIME_BITS >= 16) ? 16'hFFFF
		: 16'((32'd1 << PRIME_BITS) - 32'd1);
	localparam int KW = $clog2(INVERSE_SEARCH_LIMIT + 2);
	localparam logic [KW-1:0] KLIM = KW'(INVERSE_SEARCH_LIMIT);

	localparam logic [4:0] S_IDLE        = 5'd0;
	localparam logic [4:0] S_PR_INIT     = 5'd1;
	localparam logic [4:0] S_PR_TEST     = 5'd2;
	localparam logic [4:0] S_PR_WAIT     = 5'd3;
	localparam logic [4:0] S_N           = 5'd4;
	localparam logic [4:0] S_N_WAIT      = 5'd5;
	localparam logic [4:0] S_T           = 5'd6;
	localparam logic [4:0] S_T_WAIT      = 5'd7;
	localparam logic [4:0] S_E_TEST      = 5'd8;
	localparam logic [4:0] S_G_TEST      = 5'd9;
	localparam logic [4:0] S_G_WAIT      = 5'd10;
	localparam logic [4:0] S_MSG         = 5'd11;
	localparam logic [4:0] S_MSG_WAIT    = 5'd12;
	localparam logic [4:0] S_PW_TEST     = 5'd13;
	localparam logic [4:0] S_PW_MUL_WAIT = 5'd14;
	localparam logic [4:0] S_PW_SQ       = 5'd15;
	localparam logic [4:0] S_PW_SQ_WAIT  = 5'd16;
	localparam logic [4:0] S_K_TEST      = 5'd17;
	localparam logic [4:0] S_K_WAIT      = 5'd18;
	localparam logic [4:0] S_DONE        = 5'd19;

	logic [4:0]  state_q;
	logic [15:0] cfg_p_q, cfg_q_q;
	logic [15:0] p_q, q_q;
	logic [31:0] msg_q;
	logic        which_q;
	logic [8:0]  f_q;
	logic [17:0] sq_q;
	logic [31:0] n_q, t_q, e_q, ga_q, gb_q, acc_q, base_q;
	logic [63:0] ex_q;
	logic        phase_q;
	logic [KW-1:0] k_q;
	logic [31:0] res_cipher_q, res_rec_q, res_pub_q, res_priv_q, res_mod_q;
	logic [2:0]  res_status_q;
	logic        out_valid_q;
	logic [31:0] ciphertext_q, recovered_q, public_exponent_q;
	logic [31:0] private_exponent_q, modulus_q;
	logic [2:0]  status_q;

	logic        u_start_q;
	mdu_req_t    u_req_q;
	logic        u_done;
	mdu_rsp_t    u_rsp;

	logic [15:0] pv;
	logic        in_acc;
	logic        out_free;

	assign pv        = which_q ? q_q : p_q;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	srsa_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start_q),
		.req    (u_req_q),
		.done   (u_done),
		.rsp    (u_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_p_q <= 16'd61;
			cfg_q_q <= 16'd53;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRIME_P: cfg_p_q <= cfg_data;
				CFG_PRIME_Q: cfg_q_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			u_start_q    <= 1'b0;
			u_req_q      <= '0;
			p_q          <= '0;
			q_q          <= '0;
			msg_q        <= '0;
			which_q      <= 1'b0;
			f_q          <= '0;
			sq_q         <= '0;
			n_q          <= '0;
			t_q          <= '0;
			e_q          <= '0;
			ga_q         <= '0;
			gb_q         <= '0;
			acc_q        <= '0;
			base_q       <= '0;
			ex_q         <= '0;
			phase_q      <= 1'b0;
			k_q          <= '0;
			res_cipher_q <= '0;
			res_rec_q    <= '0;
			res_pub_q    <= '0;
			res_priv_q   <= '0;
			res_mod_q    <= '0;
			res_status_q <= ST_OK;
		end else begin
			u_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						p_q          <= cfg_p_q & PMASK;
						q_q          <= cfg_q_q & PMASK;
						msg_q        <= plaintext;
						which_q      <= 1'b0;
						res_cipher_q <= '0;
						res_rec_q    <= '0;
						res_pub_q    <= '0;
						res_priv_q   <= '0;
						res_mod_q    <= '0;
						state_q      <= S_PR_INIT;
					end
				end
				// trial division of the current candidate
				S_PR_INIT: begin
					f_q  <= 9'd2;
					sq_q <= 18'd4;
					if (pv < 16'd2) begin
						res_status_q <= which_q ? ST_BAD_Q : ST_BAD_P;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_PR_TEST;
					end
				end
				S_PR_TEST: begin
					if (sq_q > {2'd0, pv}) begin
						if (!which_q) begin
							which_q <= 1'b1;
							state_q <= S_PR_INIT;
						end else if (q_q == p_q) begin
							res_status_q <= ST_BAD_Q;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_N;
						end
					end else begin
						u_start_q <= 1'b1;
						u_req_q   <= '{a: {16'd0, pv}, b: 32'd1, c: 1'b0, m: {23'd0, f_q}};
						state_q   <= S_PR_WAIT;
					end
				end
				S_PR_WAIT: begin
					if (u_done) begin
						if (u_rsp.r == 32'd0) begin
							res_status_q <= which_q ? ST_BAD_Q : ST_BAD_P;
							state_q      <= S_DONE;
						end else begin
							sq_q    <= sq_q + 18'({f_q, 1'b0}) + 18'd1;
							f_q     <= f_q + 9'd1;
							state_q <= S_PR_TEST;
						end
					end
				end
				// modulus and totient
				S_N: begin
					u_start_q <= 1'b1;
					u_req_q   <= '{a: {16'd0, p_q}, b: {16'd0, q_q}, c: 1'b0, m: 32'd1};
					state_q   <= S_N_WAIT;
				end
				S_N_WAIT: begin
					if (u_done) begin
						n_q       <= u_rsp.q[31:0];
						res_mod_q <= u_rsp.q[31:0];
						state_q   <= S_T;
					end
				end
				S_T: begin
					u_start_q <= 1'b1;
					u_req_q   <= '{a: {16'd0, p_q - 16'd1}, b: {16'd0, q_q - 16'd1},
						c: 1'b0, m: 32'd1};
					state_q   <= S_T_WAIT;
				end
				S_T_WAIT: begin
					if (u_done) begin
						t_q     <= u_rsp.q[31:0];
						e_q     <= 32'd2;
						state_q <= S_E_TEST;
					end
				end
				// smallest exponent coprime to the totient
				S_E_TEST: begin
					if (e_q >= t_q) begin
						res_status_q <= ST_NO_E;
						state_q      <= S_DONE;
					end else begin
						ga_q    <= e_q;
						gb_q    <= t_q;
						state_q <= S_G_TEST;
					end
				end
				S_G_TEST: begin
					if (ga_q == 32'd0) begin
						if (gb_q == 32'd1) begin
							res_pub_q <= e_q;
							state_q   <= S_MSG;
						end else begin
							e_q     <= e_q + 32'd1;
							state_q <= S_E_TEST;
						end
					end else begin
						u_start_q <= 1'b1;
						u_req_q   <= '{a: gb_q, b: 32'd1, c: 1'b0, m: ga_q};
						state_q   <= S_G_WAIT;
					end
				end
				S_G_WAIT: begin
					if (u_done) begin
						gb_q    <= ga_q;
						ga_q    <= u_rsp.r;
						state_q <= S_G_TEST;
					end
				end
				// message reduced modulo n
				S_MSG: begin
					u_start_q <= 1'b1;
					u_req_q   <= '{a: msg_q, b: 32'd1, c: 1'b0, m: n_q};
					state_q   <= S_MSG_WAIT;
				end
				S_MSG_WAIT: begin
					if (u_done) begin
						base_q  <= u_rsp.r;
						acc_q   <= 32'd1;
						ex_q    <= {32'd0, e_q};
						phase_q <= 1'b0;
						state_q <= S_PW_TEST;
					end
				end
				// right-to-left square and multiply, one exponent bit per pass
				S_PW_TEST: begin
					if (ex_q == 64'd0) begin
						if (!phase_q) begin
							res_cipher_q <= acc_q;
							k_q          <= KW'(1);
							state_q      <= S_K_TEST;
						end else begin
							res_rec_q    <= acc_q;
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
					end else if (ex_q[0]) begin
						u_start_q <= 1'b1;
						u_req_q   <= '{a: acc_q, b: base_q, c: 1'b0, m: n_q};
						state_q   <= S_PW_MUL_WAIT;
					end else begin
						state_q <= S_PW_SQ;
					end
				end
				S_PW_MUL_WAIT: begin
					if (u_done) begin
						acc_q   <= u_rsp.r;
						state_q <= S_PW_SQ;
					end
				end
				S_PW_SQ: begin
					u_start_q <= 1'b1;
					u_req_q   <= '{a: base_q, b: base_q, c: 1'b0, m: n_q};
					state_q   <= S_PW_SQ_WAIT;
				end
				S_PW_SQ_WAIT: begin
					if (u_done) begin
						base_q  <= u_rsp.r;
						ex_q    <= {1'b0, ex_q[63:1]};
						state_q <= S_PW_TEST;
					end
				end
				// bounded search for the private exponent
				S_K_TEST: begin
					if (k_q > KLIM) begin
						res_status_q <= ST_NO_D;
						state_q      <= S_DONE;
					end else begin
						u_start_q <= 1'b1;
						u_req_q   <= '{a: t_q, b: 32'(k_q), c: 1'b1, m: e_q};
						state_q   <= S_K_WAIT;
					end
				end
				S_K_WAIT: begin
					if (u_done) begin
						if (u_rsp.r == 32'd0) begin
							res_priv_q <= u_rsp.q[31:0];
							ex_q       <= u_rsp.q;
							base_q     <= res_cipher_q;
							acc_q      <= 32'd1;
							phase_q    <= 1'b1;
							state_q    <= S_PW_TEST;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_K_TEST;
						end
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q        <= 1'b0;
			ciphertext_q       <= '0;
			recovered_q        <= '0;
			public_exponent_q  <= '0;
			private_exponent_q <= '0;
			modulus_q          <= '0;
			status_q           <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == S_DONE && out_free) begin
				out_valid_q        <= 1'b1;
				ciphertext_q       <= res_cipher_q;
				recovered_q        <= res_rec_q;
				public_exponent_q  <= res_pub_q;
				private_exponent_q <= res_priv_q;
				modulus_q          <= res_mod_q;
				status_q           <= res_status_q;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign ciphertext       = ciphertext_q;
	assign recovered        = recovered_q;
	assign public_exponent  = public_exponent_q;
	assign private_exponent = private_exponent_q;
	assign modulus          = modulus_q;
	assign status           = status_q;

	// accepted beat leaves the sequencer busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("sequencer idle right after accepting a beat");

	// unit completes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == S_PR_WAIT || state_q == S_N_WAIT ||
			state_q == S_T_WAIT || state_q == S_G_WAIT ||
			state_q == S_MSG_WAIT || state_q == S_PW_MUL_WAIT ||
			state_q == S_PW_SQ_WAIT || state_q == S_K_WAIT))
		else $error("arithmetic unit finished outside a wait state");

	// a bad first prime gives a zero modulus and a zero public exponent
	a_bad_p_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_BAD_P) |->
			(modulus_q == 32'd0 && public_exponent_q == 32'd0))
		else $error("bad first prime with nonzero fields");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the small-modulus rsa key setup and round trip
`timescale 1ns / 1ps

module tb_top;
	import srsa_pkg::*;

	typedef longint unsigned u64_t;

	// one result beat
	typedef struct {
		logic [31:0] ciphertext;
		logic [31:0] recovered;
		logic [31:0] public_exponent;
		logic [31:0] private_exponent;
		logic [31:0] modulus;
		logic [2:0]  status;
	} rsa_res_t;

	// directed row: primes, plaintext and an optional hand-typed result
	typedef struct {
		logic [15:0] p;
		logic [15:0] q;
		logic [31:0] pt;
		bit          typed;
		logic [2:0]  st;
		logic [31:0] n;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] plaintext;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] ciphertext;
	logic [31:0] recovered;
	logic [31:0] public_exponent;
	logic [31:0] private_exponent;
	logic [31:0] modulus;
	logic [2:0]  status;

	// primes as the block holds them
	logic [15:0] cur_p;
	logic [15:0] cur_q;

	rsa_res_t pending_results[$];
	int       fail_count;
	int       result_count;
	int       status_seen[5];
	int       sent_count;
	bit       send_burst;
	bit       recv_burst;

	small_rsa_keygen_and_modexp uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.plaintext        (plaintext),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ciphertext       (ciphertext),
		.recovered        (recovered),
		.public_exponent  (public_exponent),
		.private_exponent (private_exponent),
		.modulus          (modulus),
		.status           (status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

	// trial division, 0 and 1 not prime
	function automatic bit prime_check(u64_t v);
		u64_t f;
		if (v < 2) return 1'b0;
		for (f = 2; f * f <= v; f++) begin
			if (v % f == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic u64_t gcd64(u64_t a, u64_t b);
		u64_t r;
		while (a != 0) begin
			r = b % a;
			b = a;
			a = r;
		end
		return b;
	endfunction

	// square and multiply, m below 2^32
	function automatic u64_t pow_mod(u64_t base, u64_t ex, u64_t m);
		u64_t acc;
		acc = 1 % m;
		base = base % m;
		while (ex != 0) begin
			if (ex[0]) acc = (acc * base) % m;
			base = (base * base) % m;
			ex = ex >> 1;
		end
		return acc;
	endfunction

	// key setup and round trip for one plaintext under the current primes
	function automatic rsa_res_t rsa_round_trip(logic [31:0] pt);
		rsa_res_t r;
		u64_t p, q, n, t, e, d, c, x;
		int k;
		bit found;
		r = '{default: '0};
		p = u64_t'(cur_p);
		q = u64_t'(cur_q);
		found = 1'b0;
		d = 0;
		if (!prime_check(p)) begin
			r.status = ST_BAD_P;
			return r;
		end
		if (!prime_check(q) || q == p) begin
			r.status = ST_BAD_Q;
			return r;
		end
		n = p * q;
		t = (p - 1) * (q - 1);
		r.modulus = n[31:0];
		for (e = 2; e < t; e++) begin
			if (gcd64(e, t) == 1) break;
		end
		if (e >= t) begin
			r.status = ST_NO_E;
			return r;
		end
		r.public_exponent = e[31:0];
		c = pow_mod(u64_t'(pt), e, n);
		r.ciphertext = c[31:0];
		for (k = 1; k <= 9; k++) begin
			x = t * u64_t'(k) + 1;
			if (x % e == 0) begin
				d = x / e;
				found = 1'b1;
				break;
			end
		end
		if (!found) begin
			r.status = ST_NO_D;
			return r;
		end
		r.private_exponent = d[31:0];
		x = pow_mod(c, d, n);
		r.recovered = x[31:0];
		r.status = ST_OK;
		return r;
	endfunction

	// wait for every pending result, then a short settle
	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// one register write beat, valid left high for the caller to drop
	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PRIME_P) cur_p = val;
		else cur_q = val;
	endtask

	task automatic set_primes(logic [15:0] p, logic [15:0] q);
		drain_results();
		write_reg(CFG_PRIME_P, p);
		write_reg(CFG_PRIME_Q, q);
		cfg_valid <= 1'b0;
	endtask

	// one plaintext beat, with an optional gap in front
	task automatic send_word(logic [31:0] pt, bit typed, rsa_res_t typed_res);
		int gap;
		gap = 0;
		if (!send_burst && $urandom_range(99) < 32) gap = $urandom_range(4, 1);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		plaintext <= pt;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(typed ? typed_res : rsa_round_trip(pt));
		sent_count++;
	endtask

	// receiver: random stall, one long hold-off, check each beat
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		rsa_res_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with none pending", $time);
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (status <= 3'd4) status_seen[status]++;
					if (ciphertext !== exp_r.ciphertext || recovered !== exp_r.recovered ||
					    public_exponent !== exp_r.public_exponent ||
					    private_exponent !== exp_r.private_exponent ||
					    modulus !== exp_r.modulus || status !== exp_r.status) begin
						$display("%0t: mismatch exp c=%h r=%h e=%h d=%h n=%h st=%0d",
							$time, exp_r.ciphertext, exp_r.recovered,
							exp_r.public_exponent, exp_r.private_exponent,
							exp_r.modulus, exp_r.status);
						$display("%0t:          got c=%h r=%h e=%h d=%h n=%h st=%0d",
							$time, ciphertext, recovered, public_exponent,
							private_exponent, modulus, status);
						fail_count++;
					end
				end
				if (result_count == 40) hold_left = 15000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_burst) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 32);
			end
		end
	end

	// small primes used by the random phases
	logic [15:0] prime_pool[19] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		47, 53, 59, 61, 211};

	dir_row_t dir_rows[18] = '{
		'{16'd61, 16'd53, 32'd0, 1'b0, ST_OK, 32'd0},
		'{16'd61, 16'd53, 32'hFFFFFFFF, 1'b0, ST_OK, 32'd0},
		'{16'd61, 16'd53, 32'd1, 1'b0, ST_OK, 32'd0},
		'{16'd0, 16'd53, 32'd5, 1'b1, ST_BAD_P, 32'd0},
		'{16'd1, 16'd53, 32'd7, 1'b1, ST_BAD_P, 32'd0},
		'{16'hFFFF, 16'd53, 32'hA5A5A5A5, 1'b1, ST_BAD_P, 32'd0},
		'{16'd53, 16'd53, 32'd9, 1'b1, ST_BAD_Q, 32'd0},
		'{16'd61, 16'd0, 32'd9, 1'b1, ST_BAD_Q, 32'd0},
		'{16'd61, 16'd1, 32'd9, 1'b1, ST_BAD_Q, 32'd0},
		'{16'd61, 16'hFFFF, 32'd9, 1'b1, ST_BAD_Q, 32'd0},
		'{16'd2, 16'd3, 32'd5, 1'b1, ST_NO_E, 32'd6},
		'{16'd3, 16'd2, 32'hFFFFFFFF, 1'b1, ST_NO_E, 32'd6},
		'{16'd2, 16'd5, 32'd3, 1'b0, ST_OK, 32'd0},
		'{16'd211, 16'd2, 32'd100, 1'b0, ST_OK, 32'd0},
		'{16'd211, 16'd2, 32'h5A5A5A5A, 1'b0, ST_OK, 32'd0},
		'{16'd11, 16'd13, 32'd142, 1'b0, ST_OK, 32'd0},
		'{16'd65521, 16'd65519, 32'h12345678, 1'b0, ST_OK, 32'd0},
		'{16'd65521, 16'd2, 32'hEDCBA987, 1'b0, ST_OK, 32'd0}
	};

	// stimulus
	initial begin
		rsa_res_t typed_res;
		logic [15:0] np, nq;
		int ph, i;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_PRIME_P;
		cfg_data   = '0;
		in_valid   = 1'b0;
		plaintext  = '0;
		cur_p      = 16'd61;
		cur_q      = 16'd53;
		fail_count = 0;
		result_count = 0;
		sent_count = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		status_seen = '{default: 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset primes first
		foreach (dir_rows[r]) begin
			if (dir_rows[r].p != cur_p || dir_rows[r].q != cur_q) begin
				in_valid <= 1'b0;
				set_primes(dir_rows[r].p, dir_rows[r].q);
			end
			typed_res = '{default: '0};
			typed_res.status  = dir_rows[r].st;
			typed_res.modulus = dir_rows[r].n;
			send_word(dir_rows[r].pt, dir_rows[r].typed, typed_res);
		end

		// random phases with fresh primes, mostly valid pairs
		for (ph = 0; ph < 12; ph++) begin
			np = prime_pool[$urandom_range(18)];
			nq = prime_pool[$urandom_range(18)];
			if ($urandom_range(9) == 0) np = 16'($urandom_range(255));
			if ($urandom_range(9) == 0) nq = 16'($urandom_range(255));
			in_valid <= 1'b0;
			set_primes(np, nq);
			send_burst = (ph == 5);
			recv_burst = (ph == 8);
			for (i = 0; i < 10; i++) begin
				send_word($urandom(), 1'b0, typed_res);
			end
		end
		in_valid <= 1'b0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		drain_results();

		$display("%0d plaintext beats, %0d results checked, %0d errors", sent_count,
			result_count, fail_count);
		$display("status ok %0d, bad p %0d, bad q %0d, no e %0d, no d %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/srsa_pkg.sv
rtl/core/srsa_mdu.sv
rtl/core/small_rsa_keygen_and_modexp.sv
sim/tb_top.sv
